### hdl/pid_pkg.sv
// Shared widths, register indexes, sequencer states and unit request types for the PID step.
`timescale 1ns / 1ps
package pid_pkg;
	localparam int MUL_W  = 64;   // product and multiplicand register width
	localparam int MPL_W  = 24;   // multiplier operand width, one bit a cycle
	localparam int DVD_W  = 48;   // dividend / quotient width, one bit a cycle
	localparam int DVS_W  = 16;   // divisor width
	localparam int ACC_W  = 26;   // stored integral, holds +/- 2^24
	localparam int TRM_W  = 50;   // signed integral / derivative terms
	localparam int SUM_W  = 51;   // signed sum of the three terms
	localparam int ADDR_W = 5;

	localparam logic [DVS_W-1:0] MS_PER_S = 16'd1000;
	localparam logic [23:0] HALF_LSB = 24'd128;

	localparam logic [2:0] REG_KP   = 3'd0;
	localparam logic [2:0] REG_KI   = 3'd1;
	localparam logic [2:0] REG_KD   = 3'd2;
	localparam logic [2:0] REG_ILIM = 3'd3;
	localparam logic [2:0] REG_OMIN = 3'd4;
	localparam logic [2:0] REG_OMAX = 3'd5;
	localparam logic [2:0] REG_IWIN = 3'd6;

	localparam logic [23:0] KP_RST   = 24'd0;
	localparam logic [23:0] KI_RST   = 24'd0;
	localparam logic [23:0] KD_RST   = 24'd0;
	localparam logic [23:0] ILIM_RST = 24'hFFFFFF;
	localparam logic [15:0] OMIN_RST = 16'd0;
	localparam logic [15:0] OMAX_RST = 16'hFFFF;
	localparam logic [22:0] IWIN_RST = 23'd2560;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_MP   = 10'b0000000010,
		ST_MI1  = 10'b0000000100,
		ST_MI2  = 10'b0000001000,
		ST_DVI  = 10'b0000010000,
		ST_MD1  = 10'b0000100000,
		ST_MD2  = 10'b0001000000,
		ST_DVD  = 10'b0010000000,
		ST_SUM  = 10'b0100000000,
		ST_CLP  = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] mcand;
		logic [MPL_W-1:0] mplier;
	} mul_req_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;
endpackage

### hdl/pid_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module pid_mul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pid_pkg::mul_req_t       req,
	output logic                    done,
	output logic [pid_pkg::MUL_W-1:0] product
);
	import pid_pkg::*;

	localparam int CNT_W = $clog2(MPL_W);

	logic [MUL_W-1:0] mcand_q;
	logic [MUL_W-1:0] prod_q;
	logic [MPL_W-1:0] mplier_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MPL_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q  <= req.mcand;
			mplier_q <= req.mplier;
			prod_q   <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[MUL_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;
endmodule

### hdl/pid_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pid_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pid_pkg::div_req_t         req,
	output logic                      done,
	output logic [pid_pkg::DVD_W-1:0] quotient
);
	import pid_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;   // dividend shifts out, quotient shifts in
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

### hdl/pid_controller_step.sv
// Top level of the fixed-point PID step: config registers, sequencer, serial units.
`timescale 1ns / 1ps
// Sequence: from step transfer to result valid, five serial multiplies, two serial divides,
//   then sum and clamp. A clear transfer completes in idle and gives no result.
// Flow: one item at a time; req_ready is high only in idle. The result register
//   frees idle while a result waits; clamp holds.
// Reset: clears control state, integral and last measurement, sets first-step flag.
module pid_controller_step (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pid_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input item
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        func,
	input  logic signed [23:0]          measured,
	input  logic signed [23:0]          target,
	input  logic [15:0]                 step_ms,
	// result item
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [15:0]                 drive
);
	import pid_pkg::*;

	// configuration registers
	logic [23:0] kp_q, ki_q, kd_q, ilim_q;
	logic [15:0] omin_q, omax_q;
	logic [22:0] iwin_q;
	logic        cfg_wr;
	logic [2:0]  reg_idx;

	// sequencer and state
	state_t      state_q;
	logic signed [ACC_W-1:0] integ_q;
	logic signed [23:0]      last_q;
	logic        first_q;

	// per-step operands and terms
	logic [15:0] dt_q;
	logic [23:0] em_q;
	logic        eneg_q;
	logic        inwin_q;
	logic [23:0] dmag_q;
	logic        dpos_q;
	logic [31:0] p_q;
	logic signed [TRM_W-1:0] d_q;
	logic signed [SUM_W-1:0] sum_q;
	logic        rsp_valid_q;
	logic [15:0] drive_q;
	logic        handoff;

	// serial units
	mul_req_t         mreq;
	div_req_t         dreq;
	logic             mdone, ddone;
	logic [MUL_W-1:0] product;
	logic [DVD_W-1:0] quot;

	pid_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .product(product));
	pid_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quotient(quot));

	// ---------------- config port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= KP_RST;
			ki_q   <= KI_RST;
			kd_q   <= KD_RST;
			ilim_q <= ILIM_RST;
			omin_q <= OMIN_RST;
			omax_q <= OMAX_RST;
			iwin_q <= IWIN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_KP:   kp_q   <= pwdata[23:0];
				REG_KI:   ki_q   <= pwdata[23:0];
				REG_KD:   kd_q   <= pwdata[23:0];
				REG_ILIM: ilim_q <= pwdata[23:0];
				REG_OMIN: omin_q <= pwdata[15:0];
				REG_OMAX: omax_q <= pwdata[15:0];
				REG_IWIN: iwin_q <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KP:   prdata = {8'd0, kp_q};
			REG_KI:   prdata = {8'd0, ki_q};
			REG_KD:   prdata = {8'd0, kd_q};
			REG_ILIM: prdata = {8'd0, ilim_q};
			REG_OMIN: prdata = {16'd0, omin_q};
			REG_OMAX: prdata = {16'd0, omax_q};
			REG_IWIN: prdata = {9'd0, iwin_q};
			default:  prdata = 32'd0;
		endcase
	end

	// ---------------- input stage ----------------
	logic               acc_in;
	logic signed [24:0] err, dm;
	logic [24:0]        err_mag, dm_mag;

	assign req_ready = (state_q == ST_IDLE);
	assign acc_in    = req_valid & req_ready;
	assign err       = {target[23], target} - {measured[23], measured};
	assign dm        = {measured[23], measured} - {last_q[23], last_q};
	assign err_mag   = err[24] ? -err : err;
	assign dm_mag    = dm[24] ? -dm : dm;

	// ---------------- integral update ----------------
	logic signed [TRM_W-1:0] inc_s, acc_sum, lim_s, acc_clamped;

	assign inc_s   = eneg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
	assign acc_sum = inwin_q ? (TRM_W'(integ_q) + inc_s) : '0;
	assign lim_s   = $signed({{(TRM_W-24){1'b0}}, ilim_q});

	always_comb begin
		if (acc_sum > lim_s) begin
			acc_clamped = lim_s;
		end else if (acc_sum < -lim_s) begin
			acc_clamped = -lim_s;
		end else begin
			acc_clamped = acc_sum;
		end
	end

	// ---------------- derivative, sum, clamp ----------------
	logic signed [TRM_W-1:0] d_next;
	logic signed [32:0]      p_s;
	logic signed [SUM_W-1:0] hi_s, lo_s, res_s;
	logic [23:0]             rnd;

	assign d_next = first_q ? '0 :
		(dpos_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot}));
	assign p_s  = eneg_q ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
	assign hi_s = $signed({{(SUM_W-24){1'b0}}, omax_q, 8'd0});
	assign lo_s = $signed({{(SUM_W-24){1'b0}}, omin_q, 8'd0});

	// upper bound is tested first, so with crossed limits a sum above out_max gives out_max and any other sum out_min
	always_comb begin
		if (sum_q > hi_s) begin
			res_s = hi_s;
		end else if (sum_q < lo_s) begin
			res_s = lo_s;
		end else begin
			res_s = sum_q;
		end
	end

	// result lies in [0, 0xFFFF00], so 24 bits hold the rounded value
	assign rnd = res_s[23:0] + HALF_LSB;

	// hand off only once the previous result has been taken
	assign handoff = (state_q == ST_CLP) && (!rsp_valid_q || rsp_ready);

	// ---------------- unit requests ----------------
	always_comb begin
		mreq = '0;
		dreq = '0;
		case (state_q)
			ST_IDLE: begin
				mreq.start  = acc_in & ~func;
				mreq.mcand  = {{(MUL_W-24){1'b0}}, err_mag[23:0]};
				mreq.mplier = kp_q;
			end
			ST_MP: begin
				mreq.start  = mdone;
				mreq.mcand  = {{(MUL_W-24){1'b0}}, em_q};
				mreq.mplier = ki_q;
			end
			ST_MI1: begin
				mreq.start  = mdone;
				mreq.mcand  = product;
				mreq.mplier = {{(MPL_W-16){1'b0}}, dt_q};
			end
			ST_MI2: begin
				dreq.start    = mdone;
				dreq.dividend = product[MUL_W-1:16];
				dreq.divisor  = MS_PER_S;
			end
			ST_DVI: begin
				mreq.start  = ddone;
				mreq.mcand  = {{(MUL_W-24){1'b0}}, dmag_q};
				mreq.mplier = kd_q;
			end
			ST_MD1: begin
				mreq.start  = mdone;
				mreq.mcand  = product;
				mreq.mplier = {{(MPL_W-16){1'b0}}, MS_PER_S};
			end
			ST_MD2: begin
				dreq.start    = mdone;
				dreq.dividend = product[MUL_W-1:16];
				dreq.divisor  = dt_q;
			end
			default: ;
		endcase
	end

	// ---------------- sequencer and control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integ_q     <= '0;
			last_q      <= '0;
			first_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (handoff) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (func) begin
							integ_q <= '0;
							last_q  <= '0;
							first_q <= 1'b1;
						end else begin
							last_q  <= measured;
							state_q <= ST_MP;
						end
					end
				end
				ST_MP:  if (mdone) state_q <= ST_MI1;
				ST_MI1: if (mdone) state_q <= ST_MI2;
				ST_MI2: if (mdone) state_q <= ST_DVI;
				ST_DVI: begin
					if (ddone) begin
						integ_q <= acc_clamped[ACC_W-1:0];
						state_q <= ST_MD1;
					end
				end
				ST_MD1: if (mdone) state_q <= ST_MD2;
				ST_MD2: if (mdone) state_q <= ST_DVD;
				ST_DVD: begin
					if (ddone) begin
						first_q <= 1'b0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_CLP;
				ST_CLP: if (handoff) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (acc_in && !func) begin
			dt_q    <= (step_ms == 16'd0) ? 16'd1 : step_ms;
			em_q    <= err_mag[23:0];
			eneg_q  <= err[24];
			inwin_q <= err_mag[23:0] < {1'b0, iwin_q};
			dmag_q  <= dm_mag[23:0];
			dpos_q  <= ~dm[24] & (dm != '0);
		end
		if (state_q == ST_MP && mdone) begin
			p_q <= product[47:16];
		end
		if (state_q == ST_DVD && ddone) begin
			d_q <= d_next;
		end
		if (state_q == ST_SUM) begin
			sum_q <= SUM_W'(p_s) + SUM_W'(integ_q) + SUM_W'(d_q);
		end
		if (handoff) begin
			drive_q <= rnd[23:8];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign drive     = drive_q;
endmodule
